/* src/sorted_median_engine_top_defines.svh */
// ----------------------------------------------------------------------------
// Sorted median engine: assertion macros
// Shared property shapes for the checks in the engine's RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_MEDIAN_ENGINE_TOP_DEFINES_SVH
`define SORTED_MEDIAN_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SMED_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SMED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/smed_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted median engine package
// Word types, cell control and state encoding shared by the engine's modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smed_pkg;

  // Field widths of the input and result words.
  localparam int SAMPLE_W = 16;
  localparam int MEDIAN_W = SAMPLE_W + 1;
  localparam int COUNT_W  = 7;

  // One input word: a Q8.8 sample and the last-of-set mark.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } in_word_t;

  // One result word: the median in Q8.9, the kept count and the drop flag.
  typedef struct packed {
    logic signed [MEDIAN_W-1:0] median_value;
    logic [COUNT_W-1:0]         sample_count;
    logic                       overflowed;
  } out_word_t;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic                       insert;
    logic                       shift;
    logic signed [SAMPLE_W-1:0] sample;
  } cell_ctrl_t;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

endpackage

`default_nettype wire

/* src/smed_cell.sv */
// ----------------------------------------------------------------------------
// Sorted median engine: insertion cell
// Holds one sample of the ascending chain, makes room for a new sample by
// taking its left neighbor, and shifts toward cell zero while draining.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smed_cell (
  input  wire logic                                 clk,
  input  wire smed_pkg::cell_ctrl_t                 ctrl,
  input  wire logic                                 occupied,
  input  wire logic                                 at_end,
  input  wire logic                                 prev_gt,
  input  wire logic signed [smed_pkg::SAMPLE_W-1:0] prev_value,
  input  wire logic signed [smed_pkg::SAMPLE_W-1:0] next_value,
  output logic                                      gt,
  output logic signed [smed_pkg::SAMPLE_W-1:0]      value
);
  import smed_pkg::*;

  logic signed [SAMPLE_W-1:0] value_next;

  // The held sample is greater than the incoming one; equal values stay put,
  // so a new sample lands after any equal samples already held.
  assign gt = occupied && (value > ctrl.sample);

  // Shift down while draining; on insert, move right or take the new sample.
  always_comb begin
    value_next = value;
    if (ctrl.shift) begin
      value_next = next_value;
    end else if (ctrl.insert) begin
      if (prev_gt) begin
        value_next = prev_value;
      end else if (gt || at_end) begin
        value_next = ctrl.sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

/* src/sorted_median_engine_top.sv */
// ----------------------------------------------------------------------------
// Sorted median engine
// Median of a set of Q8.8 samples, kept sorted in a chain of insertion cells.
// ----------------------------------------------------------------------------
// Usage:
//   An input word (data) is taken at a rising edge with start high and busy
//   low. Every kept sample goes into the chain in the same edge, so words that do
//   not close a set are taken one per cycle with no gap.
//   A word with last_sample set closes the set. The chain then shifts toward
//   cell zero until the middle sample(s) reach cells zero and one, and the
//   result word is then registered. It shows up with done high for exactly
//   one cycle; busy is high while the chain drains and the result is
//   registered, and low again in the cycle where done is high.
//   The median is given in Q8.9: twice the middle sample for an odd count,
//   the sum of the two middle samples for an even count. Samples that arrive
//   with the store full are dropped and the result reports overflowed.
//   The receiver cannot stall: done is a one-cycle strobe.
//   Synchronous reset empties the set and returns to idle; the cell contents
//   are not cleared, since only held cells are ever read.
//   MAX_SAMPLES ranges from 1 to 127, the reach of the count field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_median_engine_top_defines.svh"

module sorted_median_engine_top #(
  parameter int MAX_SAMPLES = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire smed_pkg::in_word_t  data,
  output logic                     done,
  output smed_pkg::out_word_t      result
);
  import smed_pkg::*;

  localparam int CNT_W      = $clog2(MAX_SAMPLES + 1);
  localparam int SECOND_IDX = (MAX_SAMPLES > 1) ? 1 : 0;

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0] held_count;
  logic [CNT_W-1:0] held_count_next;
  logic [CNT_W-1:0] set_count;
  logic [CNT_W-1:0] remaining;
  logic             overflow_seen;
  logic             set_overflow;
  logic             set_odd;

  logic             accept;
  logic             has_room;
  logic             shift_en;
  logic             finish;
  cell_ctrl_t       ctrl;
  out_word_t        result_next;

  logic signed [SAMPLE_W-1:0] cell_value [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0]     cell_gt;

  // Word handshake and room check.
  assign accept   = start && !busy;
  assign has_room = held_count < CNT_W'(MAX_SAMPLES);
  assign held_count_next = has_room ? CNT_W'(held_count + 1'b1) : held_count;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && data.last_sample) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (remaining == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    busy     = 1'b0;
    shift_en = 1'b0;
    finish   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_DRAIN: begin
        busy     = 1'b1;
        shift_en = (remaining != '0);
        finish   = (remaining == '0);
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // Control broadcast to the cells.
  always_comb begin
    ctrl.insert = accept && has_room;
    ctrl.shift  = shift_en;
    ctrl.sample = data.sample;
  end

  // The chain of insertion cells.
  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    logic                       occupied;
    logic                       at_end;
    logic                       prev_gt;
    logic signed [SAMPLE_W-1:0] prev_value;
    logic signed [SAMPLE_W-1:0] next_value;

    assign occupied = CNT_W'(i) < held_count;
    assign at_end   = CNT_W'(i) == held_count;

    if (i == 0) begin : g_first
      assign prev_gt    = 1'b0;
      assign prev_value = cell_value[i];
    end else begin : g_inner
      assign prev_gt    = cell_gt[i-1];
      assign prev_value = cell_value[i-1];
    end

    if (i == MAX_SAMPLES - 1) begin : g_tail
      assign next_value = cell_value[i];
    end else begin : g_body
      assign next_value = cell_value[i+1];
    end

    smed_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occupied),
      .at_end     (at_end),
      .prev_gt    (prev_gt),
      .prev_value (prev_value),
      .next_value (next_value),
      .gt         (cell_gt[i]),
      .value      (cell_value[i])
    );
  end

  // Median from the head of the drained chain: cell zero, or cells zero and one.
  always_comb begin
    if (set_odd) begin
      result_next.median_value = {cell_value[0], 1'b0};
    end else begin
      result_next.median_value = {cell_value[0][SAMPLE_W-1], cell_value[0]}
                               + {cell_value[SECOND_IDX][SAMPLE_W-1],
                                  cell_value[SECOND_IDX]};
    end
    result_next.sample_count = COUNT_W'(set_count);
    result_next.overflowed   = set_overflow;
  end

  // Sequencer, set bookkeeping and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      held_count    <= '0;
      overflow_seen <= 1'b0;
      remaining     <= '0;
      done          <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
      if (accept) begin
        if (data.last_sample) begin
          held_count    <= '0;
          overflow_seen <= 1'b0;
          remaining     <= CNT_W'((held_count_next - 1'b1) >> 1);
        end else begin
          held_count    <= held_count_next;
          overflow_seen <= overflow_seen || !has_room;
        end
      end else if (shift_en) begin
        remaining <= CNT_W'(remaining - 1'b1);
      end
    end
  end

  // Closing-word capture and result payload.
  always_ff @(posedge clk) begin
    if (accept && data.last_sample) begin
      set_count    <= held_count_next;
      set_overflow <= overflow_seen || !has_room;
      set_odd      <= held_count_next[0];
    end
    if (finish) begin
      result <= result_next;
    end
  end

  // A result only follows a drain pass.
  `SMED_ASSERT_NOW(a_done_after_drain, clk, rst, done, $past(state) == ST_DRAIN,
    "result strobe without a preceding drain")
  // The store never holds more than its capacity.
  `SMED_ASSERT_NOW(a_count_in_range, clk, rst, 1'b1,
    held_count <= CNT_W'(MAX_SAMPLES), "held count beyond capacity")
  // Each drain shift brings the middle one cell closer.
  `SMED_ASSERT_NEXT(a_drain_steps, clk, rst, shift_en,
    remaining == CNT_W'($past(remaining) - 1'b1), "drain counter did not step")
  // A reported set is never empty.
  `SMED_ASSERT_NOW(a_count_nonzero, clk, rst, done, result.sample_count != '0,
    "result reports an empty set")

endmodule

`default_nettype wire

/* sim/sorted_median_engine_top_test.sv */
// ----------------------------------------------------------------------------
// Sorted median engine testbench
// Feeds sets of Q8.8 samples with random gaps and checks every median word
// against an in-bench sorted store that tracks the engine's set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_median_engine_top_test;
  import smed_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int TARGET_WORDS = 1100;
  localparam int SETTLE_CYCLES = 60;

  // One queued input word, with a request to wait for all medians first.
  typedef struct {
    in_word_t word;
    bit       wait_drain;
  } feed_item_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  logic      done;
  in_word_t  data = '0;
  out_word_t result;

  feed_item_t feed_q[$];
  out_word_t  median_expect_q[$];

  // Sorted copy of the current set, as the engine should hold it.
  logic signed [SAMPLE_W-1:0] kept_samples[CAPACITY];
  int kept_num = 0;
  bit drop_seen = 1'b0;

  bit         word_taken = 1'b0;
  bit         mismatch_seen = 1'b0;
  int         gap_left = 0;
  int         burst_left = 0;
  int         word_total = 0;
  feed_item_t head;
  out_word_t  seen;
  out_word_t  want;

  sorted_median_engine_top #(
    .MAX_SAMPLES(CAPACITY)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .data(data),
    .done(done),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Place one accepted word into the sorted set and predict its median word.
  task automatic record_sample(input in_word_t w);
    int        slot;
    int        mid;
    int        total;
    out_word_t r;
    if (kept_num < CAPACITY) begin
      slot = kept_num;
      while (slot > 0 && $signed(kept_samples[slot-1]) > $signed(w.sample)) begin
        kept_samples[slot] = kept_samples[slot-1];
        slot--;
      end
      kept_samples[slot] = w.sample;
      kept_num++;
    end else begin
      drop_seen = 1'b1;
    end
    if (w.last_sample) begin
      mid = kept_num / 2;
      if (kept_num % 2 == 1) begin
        total = 2 * int'($signed(kept_samples[mid]));
      end else begin
        total = int'($signed(kept_samples[mid-1])) + int'($signed(kept_samples[mid]));
      end
      r.median_value = total[MEDIAN_W-1:0];
      r.sample_count = kept_num[COUNT_W-1:0];
      r.overflowed   = drop_seen;
      median_expect_q.push_back(r);
      kept_num  = 0;
      drop_seen = 1'b0;
    end
  endtask

  // Idle cycles after a word: mostly none, some short, a few long, with
  // occasional bursts that run back to back.
  function automatic int pick_gap();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic add_word(input logic signed [SAMPLE_W-1:0] s, input bit last,
                          input bit drain);
    feed_item_t it;
    it.word.sample      = s;
    it.word.last_sample = last;
    it.wait_drain       = drain;
    feed_q.push_back(it);
    word_total++;
  endtask

  // One set of len samples; the value pattern picks wide, clustered,
  // extreme or monotonic contents.
  task automatic add_set(input int len, input int pattern, input bit drain);
    logic signed [SAMPLE_W-1:0] v;
    logic signed [SAMPLE_W-1:0] base;
    int                         step;
    base = SAMPLE_W'($urandom_range(0, 65535));
    step = $urandom_range(1, 300);
    for (int i = 0; i < len; i++) begin
      case (pattern)
        0: v = SAMPLE_W'($urandom_range(0, 65535));
        1: v = SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
        2: begin
          case ($urandom_range(0, 3))
            0: v = 16'sh8000;
            1: v = 16'sh7fff;
            2: v = -16'sd1;
            default: v = 16'sd0;
          endcase
        end
        3: v = base + SAMPLE_W'(i * step);
        default: v = base - SAMPLE_W'(i * step);
      endcase
      add_word(v, i == len - 1, drain && i == 0);
    end
  endtask

  // Driver: presents queued words at the falling edge and holds each one
  // until the engine takes it.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !word_taken) begin
      // Word still waiting for the engine.
    end else begin
      word_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (feed_q.size() == 0) begin
        start <= 1'b0;
      end else if (feed_q[0].wait_drain && median_expect_q.size() != 0) begin
        start <= 1'b0;
      end else begin
        head = feed_q.pop_front();
        data  <= head.word;
        start <= 1'b1;
        gap_left = pick_gap();
      end
    end
  end

  // Monitor: checks median words and records accepted input words.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        seen = result;
        if (median_expect_q.size() == 0) begin
          $error("median word with none expected: median_value %0d",
                 $signed(seen.median_value));
          mismatch_seen = 1'b1;
        end else begin
          want = median_expect_q.pop_front();
          if (seen.median_value !== want.median_value) begin
            $error("median_value expected %0d actual %0d",
                   $signed(want.median_value), $signed(seen.median_value));
            mismatch_seen = 1'b1;
          end
          if (seen.sample_count !== want.sample_count) begin
            $error("sample_count expected %0d actual %0d",
                   want.sample_count, seen.sample_count);
            mismatch_seen = 1'b1;
          end
          if (seen.overflowed !== want.overflowed) begin
            $error("overflowed expected %0d actual %0d",
                   want.overflowed, seen.overflowed);
            mismatch_seen = 1'b1;
          end
        end
      end
      if (start && !busy) begin
        record_sample(data);
        word_taken = 1'b1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int roll;
    int len;
    bit first_set;

    // Single extremes, pairs of extremes, ties, odd and even sets.
    add_word(16'sh7fff, 1'b1, 1'b0);
    add_word(16'sh8000, 1'b1, 1'b0);
    add_word(16'sh7fff, 1'b0, 1'b0);
    add_word(16'sh7fff, 1'b1, 1'b0);
    add_word(16'sh8000, 1'b0, 1'b0);
    add_word(16'sh8000, 1'b1, 1'b0);
    add_word(16'sd5, 1'b0, 1'b0);
    add_word(-16'sd3, 1'b0, 1'b0);
    add_word(16'sd5, 1'b0, 1'b0);
    add_word(16'sd0, 1'b0, 1'b0);
    add_word(16'sd5, 1'b1, 1'b0);
    add_word(16'sd100, 1'b0, 1'b0);
    add_word(-16'sd100, 1'b0, 1'b0);
    add_word(16'sd1, 1'b0, 1'b0);
    add_word(-16'sd1, 1'b1, 1'b0);
    add_word(-16'sd1, 1'b0, 1'b0);
    add_word(16'sd0, 1'b1, 1'b0);
    add_word(16'sh7fff, 1'b0, 1'b0);
    add_word(16'sh8000, 1'b0, 1'b0);
    add_word(16'sd0, 1'b1, 1'b0);
    add_word(16'sd0, 1'b1, 1'b0);

    // A full store, a dropped closing word, and a long overflow run.
    add_set(CAPACITY, 0, 1'b1);
    add_set(CAPACITY + 1, 0, 1'b0);
    add_set(CAPACITY + 9, 1, 1'b0);

    // Random sets, mostly short, some long, a few past capacity.
    first_set = 1'b1;
    while (word_total < TARGET_WORDS) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) len = $urandom_range(1, 12);
      else if (roll < 92) len = $urandom_range(13, CAPACITY - 1);
      else if (roll < 96) len = CAPACITY;
      else len = $urandom_range(CAPACITY + 1, CAPACITY + 16);
      add_set(len, $urandom_range(0, 4), first_set || $urandom_range(0, 19) == 0);
      first_set = 1'b0;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (feed_q.size() != 0 || start || median_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!mismatch_seen) begin
      $display("PASS sorted_median_engine_top");
    end else begin
      $display("FAIL sorted_median_engine_top");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("FAIL sorted_median_engine_top");
    $finish;
  end

endmodule
